// ===== rtl/ffvc_pkg.sv =====
// Shared types and constants for the first-fit vertex coloring block.
// Used by ffvc_ctrl, ffvc_dpath and the top level; depends on nothing.
package ffvc_pkg;

    localparam int ID_W    = 12;
    localparam int COLOR_W = 6;
    localparam int MAXC_W  = 7;

    localparam logic [MAXC_W-1:0] MAX_COLORS_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;     // write zero at the sweep address
        logic capture;   // input word accepted, issue table reads
        logic exec;      // apply the captured word
        logic load_out;  // load the output register with a result
    } ffvc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;  // sweep is at its final entry
        logic last;        // captured word closes its adjacency list
    } ffvc_status_t;

endpackage

// ===== rtl/ffvc_ctrl.sv =====
// Controller of the vertex coloring block: clearing sweep, word accept and
// result hand-off. Depends on ffvc_pkg.
module ffvc_ctrl
    import ffvc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  ffvc_status_t status,
    output ffvc_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // A closing word waits here until the output register is free.
                if (!status.last || out_free)
                begin
                    cmd.exec     = 1'b1;
                    cmd.load_out = status.last;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second word accepted before the first was applied");

    a_exec_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> (!cmd.clear && !cmd.capture && $past(in_ready)
                      || cmd.exec && !cmd.clear && !cmd.capture && !in_ready))
        else $error("apply overlaps clearing or accept");

endmodule

// ===== rtl/ffvc_dpath.sv =====
// Datapath of the vertex coloring block: color table, used-color mask,
// conflict flag, first-free encoder and output register. Depends on ffvc_pkg.
module ffvc_dpath
    import ffvc_pkg::*;
#(
    parameter int NODE_COUNT  = 4096,
    parameter int COLOR_LIMIT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ffvc_cmd_t          cmd,
    output ffvc_status_t       status,
    input  logic               max_colors_wr,
    input  logic [MAXC_W-1:0]  max_colors,
    input  logic               func,
    input  logic [ID_W-1:0]    vertex_id,
    input  logic [ID_W-1:0]    neighbour_id,
    input  logic               neighbour_valid,
    input  logic               last_entry,
    output logic [ID_W-1:0]    out_vertex,
    output logic [COLOR_W-1:0] vertex_color,
    output logic               conflict,
    output logic               no_free_color,
    output logic [COLOR_W-1:0] max_color_used
);

    localparam int DEPTH = (NODE_COUNT < (1 << ID_W)) ? NODE_COUNT : (1 << ID_W);
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(COLOR_LIMIT);

    logic [CW-1:0] color_mem [DEPTH];

    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [MAXC_W-1:0]      max_colors_reg;
    logic [COLOR_LIMIT-1:0] mask_reg, mask_next;
    logic                   conf_reg, conf_next;
    logic [CW-1:0]          max_reg, max_next;

    // Captured word and its table reads.
    logic                   func_reg, nvalid_reg, last_reg, v_ok_reg, w_ok_reg;
    logic [ID_W-1:0]        v_reg, w_reg;
    logic [CW-1:0]          rd_v_reg, rd_w_reg;

    logic [ID_W-1:0]        out_vertex_reg;
    logic [COLOR_W-1:0]     out_color_reg, out_max_reg;
    logic                   out_conf_reg, out_nofree_reg;

    logic                   v_ok, w_ok;
    logic [CW-1:0]          vc, wc, pick, res_color;
    logic [COLOR_LIMIT-1:0] hit_mask, mask_eff;
    logic [MAXC_W-1:0]      bound;
    logic                   found, conf_eff, do_write;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [CW-1:0]          mem_wdata;

    assign v_ok = ({1'b0, vertex_id} < (ID_W+1)'(DEPTH));
    assign w_ok = ({1'b0, neighbour_id} < (ID_W+1)'(DEPTH));

    assign vc = v_ok_reg ? rd_v_reg : '0;
    assign wc = w_ok_reg ? rd_w_reg : '0;

    assign hit_mask = {{(COLOR_LIMIT-1){1'b0}}, 1'b1} << wc;
    assign mask_eff = mask_reg | ((!func_reg && nvalid_reg) ? hit_mask : '0);
    assign conf_eff = conf_reg
                      || (func_reg && nvalid_reg && (v_reg < w_reg) && (vc == wc));

    assign bound = (max_colors_reg > MAXC_W'(COLOR_LIMIT)) ? MAXC_W'(COLOR_LIMIT)
                                                          : max_colors_reg;

    // Lowest color from one up to, but not including, the bound that no neighbour holds.
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int c = COLOR_LIMIT - 1; c >= 1; c--)
        begin
            if (!mask_eff[c] && (MAXC_W'(c) < bound))
            begin
                found = 1'b1;
                pick  = CW'(c);
            end
        end
    end

    assign do_write  = cmd.exec && last_reg && !func_reg && found && v_ok_reg;
    assign res_color = do_write ? pick : vc;

    assign max_next = (do_write && (pick > max_reg)) ? pick : max_reg;

    always_comb
    begin
        mask_next = mask_reg;
        conf_next = conf_reg;
        if (cmd.exec)
        begin
            mask_next = last_reg ? '0 : mask_eff;
            conf_next = last_reg ? 1'b0 : conf_eff;
        end
    end

    assign clr_cnt_next = cmd.clear ? clr_cnt_reg + AW'(1) : clr_cnt_reg;

    assign status.clear_done = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.last       = last_reg;

    assign mem_we    = cmd.clear || do_write;
    assign mem_waddr = cmd.clear ? clr_cnt_reg : v_reg[AW-1:0];
    assign mem_wdata = cmd.clear ? '0 : pick;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture)
        begin
            rd_v_reg <= color_mem[vertex_id[AW-1:0]];
            rd_w_reg <= color_mem[neighbour_id[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func;
            v_reg      <= vertex_id;
            w_reg      <= neighbour_id;
            nvalid_reg <= neighbour_valid;
            last_reg   <= last_entry;
            v_ok_reg   <= v_ok;
            w_ok_reg   <= w_ok;
        end
        if (cmd.load_out)
        begin
            out_vertex_reg <= v_reg;
            out_color_reg  <= COLOR_W'(res_color);
            out_conf_reg   <= func_reg && conf_eff;
            out_nofree_reg <= !func_reg && !found;
            out_max_reg    <= COLOR_W'(max_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            max_colors_reg <= MAX_COLORS_RESET;
            mask_reg       <= '0;
            conf_reg       <= 1'b0;
            max_reg        <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            if (max_colors_wr)
            begin
                max_colors_reg <= max_colors;
            end
            mask_reg <= mask_next;
            conf_reg <= conf_next;
            max_reg  <= max_next;
        end
    end

    assign out_vertex     = out_vertex_reg;
    assign vertex_color   = out_color_reg;
    assign conflict       = out_conf_reg;
    assign no_free_color  = out_nofree_reg;
    assign max_color_used = out_max_reg;

    a_max_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (max_reg >= $past(max_reg)))
        else $error("running maximum color decreased");

    a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> !do_write)
        else $error("color written during the clearing sweep");

    a_list_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && last_reg) |=> (mask_reg == '0 && !conf_reg))
        else $error("mask or conflict flag survived the end of a list");

endmodule

// ===== rtl/first_fit_vertex_coloring.sv =====
// First-fit vertex coloring: after reset the color table is swept to zero,
// one entry per cycle over all min(NODE_COUNT, 4096) entries, with in_ready low
// (max_colors writes are taken during the sweep). After that each adjacency
// word is accepted, then applied: on accept the vertex and neighbour colors are
// read into registers from the two read ports of the table; in the apply
// state the mask or conflict flag is updated and, on a closing word, the
// chosen color is written back and the result register loaded. No new word
// is taken until the last one is applied. A closing word waits while an
// earlier result is still unread in the output register; other words never
// wait on it. Depends on ffvc_pkg, ffvc_ctrl and ffvc_dpath.
module first_fit_vertex_coloring
    import ffvc_pkg::*;
#(
    parameter int NODE_COUNT  = 4096,
    parameter int COLOR_LIMIT = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               max_colors_wr,
    input  logic [MAXC_W-1:0]  max_colors,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [ID_W-1:0]    vertex_id,
    input  logic [ID_W-1:0]    neighbour_id,
    input  logic               neighbour_valid,
    input  logic               last_entry,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ID_W-1:0]    out_vertex,
    output logic [COLOR_W-1:0] vertex_color,
    output logic               conflict,
    output logic               no_free_color,
    output logic [COLOR_W-1:0] max_color_used
);

    ffvc_cmd_t    cmd;
    ffvc_status_t status;

    ffvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ffvc_dpath #(
        .NODE_COUNT  (NODE_COUNT),
        .COLOR_LIMIT (COLOR_LIMIT)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .max_colors_wr   (max_colors_wr),
        .max_colors      (max_colors),
        .func            (func),
        .vertex_id       (vertex_id),
        .neighbour_id    (neighbour_id),
        .neighbour_valid (neighbour_valid),
        .last_entry      (last_entry),
        .out_vertex      (out_vertex),
        .vertex_color    (vertex_color),
        .conflict        (conflict),
        .no_free_color   (no_free_color),
        .max_color_used  (max_color_used)
    );

endmodule

// ===== test/tb_first_fit_vertex_coloring.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_vertex_coloring: a clocked driver and
// monitor around a cycle-free predictor that mirrors the color table.
// Depends on ffvc_pkg and the first_fit_vertex_coloring RTL.
module tb_first_fit_vertex_coloring;
    import ffvc_pkg::*;

    localparam int NODE_COUNT    = 4096;
    localparam int COLOR_LIMIT   = 64;
    localparam logic FUNC_COLOR  = 1'b0;
    localparam logic FUNC_CHECK  = 1'b1;
    localparam int PHASES        = 10;
    localparam int WORDS_PER_PHASE = 185;
    localparam int IDLE_MAX      = 18;
    localparam int LONG_HOLD     = 600;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 20000;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic              func;
        logic [ID_W-1:0]   vertex;
        logic [ID_W-1:0]   neighbour;
        logic              nvalid;
        logic              last;
    } adj_word_t;

    typedef struct packed {
        logic [ID_W-1:0]    vertex;
        logic [COLOR_W-1:0] color;
        logic               conflict;
        logic               no_free;
        logic [COLOR_W-1:0] max_used;
    } color_result_t;

    logic               clk;
    logic               rst_n;
    logic               max_colors_wr;
    logic [MAXC_W-1:0]  max_colors;
    logic               in_valid;
    logic               in_ready;
    logic               func;
    logic [ID_W-1:0]    vertex_id;
    logic [ID_W-1:0]    neighbour_id;
    logic               neighbour_valid;
    logic               last_entry;
    logic               out_valid;
    logic               out_ready;
    logic [ID_W-1:0]    out_vertex;
    logic [COLOR_W-1:0] vertex_color;
    logic               conflict;
    logic               no_free_color;
    logic [COLOR_W-1:0] max_color_used;

    // Predictor state: a mirror of everything the block keeps.
    logic [COLOR_W-1:0] color_mirror [NODE_COUNT];
    logic [63:0]        used_mirror;
    logic               conflict_mirror;
    logic [COLOR_W-1:0] max_mirror;
    logic [MAXC_W-1:0]  bound_mirror;

    adj_word_t     pending_words [$];
    color_result_t predicted_results [$];
    adj_word_t     cur_word;

    int  tx_gap;
    int  rx_gap;
    int  rx_hold;
    int  tx_idle_max;
    int  rx_idle_max;
    logic hold_req;
    int  mismatches;
    int  words_accepted;
    int  results_checked;
    int  bound_writes;
    int  stall_cycles;

    first_fit_vertex_coloring #(
        .NODE_COUNT  (NODE_COUNT),
        .COLOR_LIMIT (COLOR_LIMIT)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_colors_wr   (max_colors_wr),
        .max_colors      (max_colors),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .vertex_id       (vertex_id),
        .neighbour_id    (neighbour_id),
        .neighbour_valid (neighbour_valid),
        .last_entry      (last_entry),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_vertex      (out_vertex),
        .vertex_color    (vertex_color),
        .conflict        (conflict),
        .no_free_color   (no_free_color),
        .max_color_used  (max_color_used)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Greedy first-fit step for one accepted word.
    task automatic first_fit_predict(input adj_word_t w);
        logic [COLOR_W-1:0] vc;
        logic [COLOR_W-1:0] wc;
        int bound;
        color_result_t r;
        vc = color_mirror[w.vertex];
        if (w.nvalid)
        begin
            wc = color_mirror[w.neighbour];
            if (w.func == FUNC_COLOR)
                used_mirror[wc] = 1'b1;
            else if (w.vertex < w.neighbour && vc == wc)
                conflict_mirror = 1'b1;
        end
        if (w.last)
        begin
            r.conflict = 1'b0;
            r.no_free  = 1'b0;
            if (w.func == FUNC_COLOR)
            begin
                bound = (bound_mirror > COLOR_LIMIT) ? COLOR_LIMIT : bound_mirror;
                r.no_free = 1'b1;
                for (int c = 1; c < bound; c++)
                begin
                    if (!used_mirror[c])
                    begin
                        vc = c[COLOR_W-1:0];
                        color_mirror[w.vertex] = vc;
                        if (vc > max_mirror)
                            max_mirror = vc;
                        r.no_free = 1'b0;
                        break;
                    end
                end
            end
            else
            begin
                r.conflict = conflict_mirror;
            end
            used_mirror     = '0;
            conflict_mirror = 1'b0;
            r.vertex   = w.vertex;
            r.color    = vc;
            r.max_used = max_mirror;
            predicted_results.insert(predicted_results.size(), r);
        end
    endtask

    // Driver: holds each word until it is taken, then waits a drawn gap.
    always @(posedge clk)
    begin : driver
        adj_word_t nxt;
        logic slot_free;
        if (rst_n)
        begin
            slot_free = !in_valid || in_ready;
            if (in_valid && in_ready)
            begin
                first_fit_predict(cur_word);
                words_accepted++;
            end
            if (slot_free)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    nxt = pending_words.pop_front();
                    cur_word        <= nxt;
                    in_valid        <= 1'b1;
                    func            <= nxt.func;
                    vertex_id       <= nxt.vertex;
                    neighbour_id    <= nxt.neighbour;
                    neighbour_valid <= nxt.nvalid;
                    last_entry      <= nxt.last;
                    tx_gap = $urandom_range(0, tx_idle_max);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result word with the oldest prediction.
    always @(posedge clk)
    begin : monitor
        color_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (predicted_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result for vertex %0d", out_vertex));
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (out_vertex !== want.vertex)
                        report_mismatch($sformatf("out_vertex got %0d want %0d",
                                                  out_vertex, want.vertex));
                    if (vertex_color !== want.color)
                        report_mismatch($sformatf("vertex %0d: vertex_color got %0d want %0d",
                                                  want.vertex, vertex_color, want.color));
                    if (conflict !== want.conflict)
                        report_mismatch($sformatf("vertex %0d: conflict got %0b want %0b",
                                                  want.vertex, conflict, want.conflict));
                    if (no_free_color !== want.no_free)
                        report_mismatch($sformatf("vertex %0d: no_free_color got %0b want %0b",
                                                  want.vertex, no_free_color, want.no_free));
                    if (max_color_used !== want.max_used)
                        report_mismatch($sformatf("vertex %0d: max_color_used got %0d want %0d",
                                                  want.vertex, max_color_used, want.max_used));
                end
                rx_gap = $urandom_range(0, rx_idle_max);
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
            end
            if (hold_req)
            begin
                rx_hold = LONG_HOLD;
                hold_req <= 1'b0;
            end
            else if (rx_hold > 0)
            begin
                rx_hold--;
            end
            out_ready <= (rx_hold == 0) && (rx_gap == 0);
        end
    end

    // The reset sweep shows up here as a long quiet stretch, so the limit is generous.
    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic logic [ID_W-1:0] pick_id();
        // Mostly a small pool so that neighbours carry colors.
        if ($urandom_range(0, 3) != 0)
            return ID_W'($urandom_range(0, 31));
        return ID_W'($urandom_range(0, NODE_COUNT - 1));
    endfunction

    task automatic push_word(input logic f, input logic [ID_W-1:0] v,
                             input logic [ID_W-1:0] n, input logic nv, input logic last);
        adj_word_t w;
        w.func      = f;
        w.vertex    = v;
        w.neighbour = n;
        w.nvalid    = nv;
        w.last      = last;
        pending_words.insert(pending_words.size(), w);
    endtask

    // Idle means nothing queued, nothing offered and nothing outstanding,
    // plus a margin for words that close no list.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_words.size() != 0 || in_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_colors(input logic [MAXC_W-1:0] value);
        @(posedge clk);
        max_colors_wr <= 1'b1;
        max_colors    <= value;
        @(posedge clk);
        max_colors_wr <= 1'b0;
        bound_mirror = value;
        bound_writes++;
    endtask

    initial
    begin : stimulus
        logic              f;
        logic [ID_W-1:0]   v;
        logic [MAXC_W-1:0] bound_sel;
        int n;
        int len;

        rst_n           = 1'b0;
        max_colors_wr   = 1'b0;
        max_colors      = MAX_COLORS_RESET;
        in_valid        = 1'b0;
        func            = FUNC_COLOR;
        vertex_id       = '0;
        neighbour_id    = '0;
        neighbour_valid = 1'b0;
        last_entry      = 1'b0;
        out_ready       = 1'b0;
        hold_req        = 1'b0;
        tx_gap = 0;
        rx_gap = 0;
        rx_hold = 0;
        tx_idle_max = IDLE_MAX;
        rx_idle_max = IDLE_MAX;
        mismatches = 0;
        words_accepted = 0;
        results_checked = 0;
        bound_writes = 0;
        stall_cycles = 0;
        foreach (color_mirror[i])
            color_mirror[i] = '0;
        used_mirror     = '0;
        conflict_mirror = 1'b0;
        max_mirror      = '0;
        bound_mirror    = MAX_COLORS_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_max_colors(7'd64);

        // Directed lists at the full bound.
        @(negedge clk);
        push_word(FUNC_COLOR, 12'd0, 12'd0, 1'b0, 1'b1);       // no neighbours
        push_word(FUNC_COLOR, 12'd4095, 12'd0, 1'b1, 1'b1);    // largest id
        push_word(FUNC_COLOR, 12'd0, 12'd0, 1'b1, 1'b1);       // self loop
        push_word(FUNC_CHECK, 12'd0, 12'd4095, 1'b1, 1'b1);    // larger neighbour, same color
        push_word(FUNC_CHECK, 12'd4095, 12'd0, 1'b1, 1'b1);    // smaller neighbour ignored
        push_word(FUNC_CHECK, 12'd100, 12'd200, 1'b1, 1'b0);   // two uncolored vertices
        push_word(FUNC_CHECK, 12'd100, 12'd300, 1'b1, 1'b1);
        push_word(FUNC_COLOR, 12'd7, 12'd4095, 1'b0, 1'b1);
        // The invalid entry points at a color-1 vertex and must add nothing.
        push_word(FUNC_COLOR, 12'd5, 12'd7, 1'b0, 1'b0);
        push_word(FUNC_COLOR, 12'd5, 12'd0, 1'b1, 1'b1);
        // Mixed modes: a pending conflict is dropped when a color word closes the list.
        push_word(FUNC_CHECK, 12'd5, 12'd7, 1'b1, 1'b0);
        push_word(FUNC_COLOR, 12'd8, 12'd7, 1'b1, 1'b1);
        push_word(FUNC_CHECK, 12'd5, 12'd300, 1'b1, 1'b1);
        // Mixed vertices: the closing word names the vertex that is colored.
        push_word(FUNC_COLOR, 12'd9, 12'd0, 1'b1, 1'b0);
        push_word(FUNC_COLOR, 12'd10, 12'd5, 1'b1, 1'b1);
        push_word(FUNC_CHECK, 12'd3000, 12'd3001, 1'b1, 1'b0);  // no result
        wait_drained();

        // Only color 1 is usable.
        set_max_colors(7'd2);
        @(negedge clk);
        push_word(FUNC_COLOR, 12'd0, 12'd7, 1'b1, 1'b1);
        push_word(FUNC_COLOR, 12'd11, 12'd0, 1'b0, 1'b1);
        wait_drained();
        // No usable color at all.
        set_max_colors(7'd0);
        @(negedge clk);
        push_word(FUNC_COLOR, 12'd12, 12'd0, 1'b0, 1'b1);
        wait_drained();
        set_max_colors(7'd1);
        @(negedge clk);
        push_word(FUNC_COLOR, 12'd0, 12'd0, 1'b0, 1'b1);
        wait_drained();
        // A bound above the color limit saturates.
        set_max_colors(7'd127);
        @(negedge clk);
        push_word(FUNC_COLOR, 12'd13, 12'd10, 1'b1, 1'b0);
        push_word(FUNC_COLOR, 12'd13, 12'd8, 1'b1, 1'b1);
        push_word(FUNC_CHECK, 12'd8, 12'd13, 1'b1, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: bound_sel = 7'd64;
                1: bound_sel = 7'd127;
                2: bound_sel = 7'd2;
                3: bound_sel = 7'd40;
                4: bound_sel = 7'd0;
                5: bound_sel = 7'd64;
                6: bound_sel = 7'd1;
                8: bound_sel = 7'd3;
                9: bound_sel = 7'd64;
                default: bound_sel = MAXC_W'($urandom_range(0, 127));
            endcase
            set_max_colors(bound_sel);
            tx_idle_max = (p % 3 == 1) ? 0 : IDLE_MAX;
            rx_idle_max = (p % 4 == 2) ? 0 : IDLE_MAX;
            if (p == 0 || p == 5)
            begin
                // The sink stalls while words keep coming, so the block backs up.
                tx_idle_max = 0;
                hold_req <= 1'b1;
            end
            @(negedge clk);
            n = 0;
            while (n < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    f = ($urandom_range(0, 99) < 35) ? FUNC_CHECK : FUNC_COLOR;
                    v = pick_id();
                    if ($urandom_range(0, 19) == 0)
                        len = $urandom_range(30, 70);
                    else
                        len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                        push_word(f, v, pick_id(), $urandom_range(0, 9) != 0, k == len - 1);
                    n += len;
                end
                else
                begin
                    push_word(1'($urandom_range(0, 1)), pick_id(),
                              ID_W'($urandom_range(0, NODE_COUNT - 1)),
                              1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
                    n++;
                end
            end
        end
        wait_drained();

        $display("Covered %0d adjacency words and %0d result words over %0d bound settings,",
                 words_accepted, results_checked, bound_writes);
        $display("with random gaps on both sides and long output stalls; %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
